@@ design/tdc_pkg.sv @@
`timescale 1ns / 1ps

package tdc_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int COORD_BITS_DEF    = 24;

  localparam int ANGLE_W   = 13;
  localparam int DIR_W     = 12;
  localparam int ZW        = 30;
  localparam int ANG_FRAC  = 16;
  localparam int ROT_FRAC  = 30;
  localparam int VEC_FRAC  = 28;
  localparam int GAIN_W    = 31;
  localparam int GUARD_W   = 3;

  localparam int ANG_FULL  = 3600;
  localparam int ANG_HALF  = 1800;
  localparam int ANG_QTR   = 900;
  localparam int ANG_ONE   = 65536;

  localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;
  localparam logic signed [ZW-1:0]     Z_FULL   = ZW'(ANG_FULL * ANG_ONE);
  localparam logic signed [ZW-1:0]     Z_HALF   = ZW'(ANG_HALF * ANG_ONE);

  typedef struct packed {
    logic vld;
    logic vec;
    logic zero;
  } ctl_t;

  function automatic logic signed [ZW-1:0] atan_tenths(input int unsigned idx);
    logic [25:0] v;
    case (idx)
      0:       v = 26'd29491200;
      1:       v = 26'd17409672;
      2:       v = 26'd9198793;
      3:       v = 26'd4669451;
      4:       v = 26'd2343786;
      5:       v = 26'd1173036;
      6:       v = 26'd586661;
      7:       v = 26'd293348;
      8:       v = 26'd146676;
      9:       v = 26'd73339;
      10:      v = 26'd36669;
      11:      v = 26'd18335;
      12:      v = 26'd9167;
      13:      v = 26'd4584;
      14:      v = 26'd2292;
      15:      v = 26'd1146;
      16:      v = 26'd573;
      17:      v = 26'd286;
      18:      v = 26'd143;
      19:      v = 26'd72;
      20:      v = 26'd36;
      21:      v = 26'd18;
      22:      v = 26'd9;
      23:      v = 26'd4;
      24:      v = 26'd2;
      25:      v = 26'd1;
      26:      v = 26'd1;
      default: v = 26'd0;
    endcase
    return ZW'(v);
  endfunction

endpackage

@@ design/tdc_prep.sv @@
`timescale 1ns / 1ps

module tdc_prep #(
  parameter int CW = tdc_pkg::COORD_BITS_DEF,
  parameter int DW = tdc_pkg::COORD_BITS_DEF + tdc_pkg::ROT_FRAC + tdc_pkg::GUARD_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic                          func_i,
  input  logic signed [CW-1:0]          x_i,
  input  logic signed [CW-1:0]          y_i,
  input  logic signed [tdc_pkg::ANGLE_W-1:0] angle_i,
  output tdc_pkg::ctl_t                 ctl_o,
  output logic signed [DW-1:0]          x_o,
  output logic signed [DW-1:0]          y_o,
  output logic signed [tdc_pkg::ZW-1:0] z_o
);
  import tdc_pkg::*;

  logic signed [ANGLE_W:0]      a_ext;
  logic signed [ANGLE_W:0]      a_wrap;
  logic signed [ANGLE_W:0]      a_half;
  logic                         neg_rot;
  logic                         neg;
  ctl_t                         ctl1_nxt, ctl1_r;
  logic signed [CW:0]           cx1_nxt, cx1_r;
  logic signed [CW:0]           cy1_nxt, cy1_r;
  logic signed [ZW-1:0]         z1_nxt, z1_r;

  logic signed [CW+GAIN_W:0]    prod_x;
  logic signed [CW+GAIN_W:0]    prod_y;
  ctl_t                         ctl2_r;
  logic signed [DW-1:0]         x2_nxt, x2_r;
  logic signed [DW-1:0]         y2_nxt, y2_r;
  logic signed [ZW-1:0]         z2_r;

  always_comb begin
    a_ext = (ANGLE_W+1)'(angle_i);
    if (a_ext > ANG_HALF) begin
      a_wrap = a_ext - (ANGLE_W+1)'(ANG_FULL);
    end else if (a_ext <= -ANG_HALF) begin
      a_wrap = a_ext + (ANGLE_W+1)'(ANG_FULL);
    end else begin
      a_wrap = a_ext;
    end

    if (a_wrap > ANG_QTR) begin
      a_half  = a_wrap - (ANGLE_W+1)'(ANG_HALF);
      neg_rot = 1'b1;
    end else if (a_wrap < -ANG_QTR) begin
      a_half  = a_wrap + (ANGLE_W+1)'(ANG_HALF);
      neg_rot = 1'b1;
    end else begin
      a_half  = a_wrap;
      neg_rot = 1'b0;
    end

    neg = func_i ? x_i[CW-1] : neg_rot;

    ctl1_nxt.vld  = vld_i;
    ctl1_nxt.vec  = func_i;
    ctl1_nxt.zero = (x_i == '0) && (y_i == '0);

    cx1_nxt = neg ? -((CW+1)'(x_i)) : (CW+1)'(x_i);
    cy1_nxt = neg ? -((CW+1)'(y_i)) : (CW+1)'(y_i);

    if (func_i) begin
      z1_nxt = neg ? Z_HALF : '0;
    end else begin
      z1_nxt = ZW'(a_half) <<< ANG_FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cx1_r <= cx1_nxt;
    cy1_r <= cy1_nxt;
    z1_r  <= z1_nxt;
  end

  always_comb begin
    prod_x = cx1_r * GAIN_Q30;
    prod_y = cy1_r * GAIN_Q30;
    if (ctl1_r.vec) begin
      x2_nxt = DW'(cx1_r) <<< VEC_FRAC;
      y2_nxt = DW'(cy1_r) <<< VEC_FRAC;
    end else begin
      x2_nxt = DW'(prod_x);
      y2_nxt = DW'(prod_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    x2_r <= x2_nxt;
    y2_r <= y2_nxt;
    z2_r <= z1_r;
  end

  assign ctl_o = ctl2_r;
  assign x_o   = x2_r;
  assign y_o   = y2_r;
  assign z_o   = z2_r;

endmodule

@@ design/tdc_stage.sv @@
`timescale 1ns / 1ps

module tdc_stage #(
  parameter int DW  = tdc_pkg::COORD_BITS_DEF + tdc_pkg::ROT_FRAC + tdc_pkg::GUARD_W,
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tdc_pkg::ctl_t                 ctl_i,
  input  logic signed [DW-1:0]          x_i,
  input  logic signed [DW-1:0]          y_i,
  input  logic signed [tdc_pkg::ZW-1:0] z_i,
  output tdc_pkg::ctl_t                 ctl_o,
  output logic signed [DW-1:0]          x_o,
  output logic signed [DW-1:0]          y_o,
  output logic signed [tdc_pkg::ZW-1:0] z_o
);
  import tdc_pkg::*;

  localparam logic signed [ZW-1:0] ATAN_I = atan_tenths(IDX);

  logic                 sub;
  logic signed [DW-1:0] dx, dy;
  logic signed [DW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  ctl_t                 ctl_r;
  logic signed [DW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;

  always_comb begin
    sub = ctl_i.vec ? y_i[DW-1] : !z_i[ZW-1];
    dx  = y_i >>> IDX;
    dy  = x_i >>> IDX;
    if (sub) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN_I;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN_I;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

@@ design/tdc_post.sv @@
`timescale 1ns / 1ps

module tdc_post #(
  parameter int CW = tdc_pkg::COORD_BITS_DEF,
  parameter int DW = tdc_pkg::COORD_BITS_DEF + tdc_pkg::ROT_FRAC + tdc_pkg::GUARD_W
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tdc_pkg::ctl_t                    ctl_i,
  input  logic signed [DW-1:0]             x_i,
  input  logic signed [DW-1:0]             y_i,
  input  logic signed [tdc_pkg::ZW-1:0]    z_i,
  output logic                             strobe_o,
  output logic signed [CW:0]               x_o,
  output logic signed [CW:0]               y_o,
  output logic [tdc_pkg::DIR_W-1:0]        dir_o
);
  import tdc_pkg::*;

  logic                 rnd_x, rnd_y;
  logic signed [DW-1:0] x_tr, y_tr;
  logic signed [ZW-1:0] z_wrap;
  logic [DIR_W:0]       dir_raw;
  logic [DIR_W:0]       dir_fix;
  logic                 strobe_r;
  logic signed [CW:0]   x_nxt, x_r;
  logic signed [CW:0]   y_nxt, y_r;
  logic [DIR_W-1:0]     dir_nxt, dir_r;

  always_comb begin
    rnd_x = x_i[DW-1] && (x_i[ROT_FRAC-1:0] != '0);
    rnd_y = y_i[DW-1] && (y_i[ROT_FRAC-1:0] != '0);
    x_tr  = (x_i >>> ROT_FRAC) + DW'(rnd_x);
    y_tr  = (y_i >>> ROT_FRAC) + DW'(rnd_y);

    z_wrap = z_i[ZW-1] ? z_i + Z_FULL : z_i;
    if (z_wrap[ZW-1]) begin
      dir_raw = '0;
    end else begin
      dir_raw = z_wrap[ANG_FRAC+DIR_W:ANG_FRAC];
    end
    if (dir_raw >= (DIR_W+1)'(ANG_FULL)) begin
      dir_fix = dir_raw - (DIR_W+1)'(ANG_FULL);
    end else begin
      dir_fix = dir_raw;
    end
    if (dir_fix >= (DIR_W+1)'(ANG_FULL)) begin
      dir_fix = '0;
    end

    if (ctl_i.vec) begin
      x_nxt   = '0;
      y_nxt   = '0;
      dir_nxt = ctl_i.zero ? '0 : dir_fix[DIR_W-1:0];
    end else begin
      x_nxt   = x_tr[CW:0];
      y_nxt   = y_tr[CW:0];
      dir_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    dir_r <= dir_nxt;
  end

  assign strobe_o = strobe_r;
  assign x_o      = x_r;
  assign y_o      = y_r;
  assign dir_o    = dir_r;

endmodule

@@ design/tenth_degree_cordic_unit.sv @@
`timescale 1ns / 1ps
// Throughput: one item per cycle; prep, multiply, one register per CORDIC
// iteration and one output register, with busy low once reset is over.
// Results cannot be held off, so nothing in the pipeline ever stalls.
// Reset: synchronous, active low; clears all valid bits, busy high during reset.

module tenth_degree_cordic_unit #(
  parameter int CORDIC_STAGES = tdc_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_BITS    = tdc_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_func,
  input  logic signed [COORD_BITS-1:0]       in_x,
  input  logic signed [COORD_BITS-1:0]       in_y,
  input  logic signed [tdc_pkg::ANGLE_W-1:0] in_angle,
  output logic                               out_strobe,
  output logic signed [COORD_BITS:0]         out_x,
  output logic signed [COORD_BITS:0]         out_y,
  output logic [tdc_pkg::DIR_W-1:0]          out_direction
);
  import tdc_pkg::*;

  localparam int DW = COORD_BITS + ROT_FRAC + GUARD_W;

  logic                 busy_r;
  logic                 accept;
  ctl_t                 ctl_s [CORDIC_STAGES+1];
  logic signed [DW-1:0] x_s   [CORDIC_STAGES+1];
  logic signed [DW-1:0] y_s   [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_s   [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  tdc_prep #(
    .CW (COORD_BITS),
    .DW (DW)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (accept),
    .func_i  (in_func),
    .x_i     (in_x),
    .y_i     (in_y),
    .angle_i (in_angle),
    .ctl_o   (ctl_s[0]),
    .x_o     (x_s[0]),
    .y_o     (y_s[0]),
    .z_o     (z_s[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    tdc_stage #(
      .DW  (DW),
      .IDX (g)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[g]),
      .x_i   (x_s[g]),
      .y_i   (y_s[g]),
      .z_i   (z_s[g]),
      .ctl_o (ctl_s[g+1]),
      .x_o   (x_s[g+1]),
      .y_o   (y_s[g+1]),
      .z_o   (z_s[g+1])
    );
  end

  tdc_post #(
    .CW (COORD_BITS),
    .DW (DW)
  ) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (ctl_s[CORDIC_STAGES]),
    .x_i      (x_s[CORDIC_STAGES]),
    .y_i      (y_s[CORDIC_STAGES]),
    .z_i      (z_s[CORDIC_STAGES]),
    .strobe_o (out_strobe),
    .x_o      (out_x),
    .y_o      (out_y),
    .dir_o    (out_direction)
  );

endmodule

@@ design/tdc_checker.sv @@
`timescale 1ns / 1ps

module tdc_checker #(
  parameter int CORDIC_STAGES = tdc_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_BITS    = tdc_pkg::COORD_BITS_DEF
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               in_func,
  input logic signed [COORD_BITS-1:0]       in_x,
  input logic signed [COORD_BITS-1:0]       in_y,
  input logic signed [tdc_pkg::ANGLE_W-1:0] in_angle,
  input logic                               out_strobe,
  input logic signed [COORD_BITS:0]         out_x,
  input logic signed [COORD_BITS:0]         out_y,
  input logic [tdc_pkg::DIR_W-1:0]          out_direction
);
  import tdc_pkg::*;

  localparam int LAT = CORDIC_STAGES + 3;

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy high outside reset");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result without an accepted item");

  a_vec_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(in_func, LAT) |->
      out_x == '0 && out_y == '0 && out_direction < DIR_W'(ANG_FULL))
    else $error("vector result out of range");

  a_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(in_func && in_x == '0 && in_y == '0, LAT) |->
      out_direction == '0)
    else $error("zero vector gave nonzero direction");

  a_rot_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !$past(in_func, LAT) |-> out_direction == '0)
    else $error("rotate result with nonzero direction");

endmodule

bind tenth_degree_cordic_unit tdc_checker #(
  .CORDIC_STAGES (CORDIC_STAGES),
  .COORD_BITS    (COORD_BITS)
) u_tdc_checker (.*);
